// ===== rtl/ppmenc_pkg.sv =====
// Shared types and constants for the two-bit PPM IR symbol encoder.
// No dependencies; imported by every module of the block.
package ppmenc_pkg;

    localparam int TICK_W    = 15;
    localparam int BYTE_W    = 8;
    localparam int SYM_W     = 2;
    localparam int NUM_SYM   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int SEQ_W     = 3;

    // Pulse index within one request: symbols 0..3, then the closing burst
    localparam logic [SEQ_W-1:0] SEQ_LAST_SYM = SEQ_W'(NUM_SYM - 1);
    localparam logic [SEQ_W-1:0] SEQ_CLOSE    = SEQ_W'(NUM_SYM);

    localparam logic [TICK_W-1:0] BURST_RST = TICK_W'(403);
    localparam logic [TICK_W-1:0] GAP0_RST  = TICK_W'(605);
    localparam logic [TICK_W-1:0] GAP1_RST  = TICK_W'(1814);
    localparam logic [TICK_W-1:0] GAP2_RST  = TICK_W'(1210);
    localparam logic [TICK_W-1:0] GAP3_RST  = TICK_W'(2419);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BURST = 3'd0,
        REG_GAP0  = 3'd1,
        REG_GAP1  = 3'd2,
        REG_GAP2  = 3'd3,
        REG_GAP3  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
    } t_cmd;

    typedef struct packed {
        logic [TICK_W-1:0]               burst;
        logic [NUM_SYM-1:0][TICK_W-1:0]  gap;
    } t_cfg;

    typedef struct packed {
        logic [TICK_W-1:0] burst_len;
        logic [TICK_W-1:0] gap_len;
        logic [SYM_W-1:0]  symbol_value;
        logic              closing;
        logic              last;
    } t_result;

    // Handshake between front command queue and back sequencer
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage

// ===== rtl/ppm_ir_symbol_encoder.sv =====
// Path: a byte accepted into an idle block is registered in the front queue, and its first
// pulse is then registered in the back-end output register before it is on the outputs.
// Throughput: one pulse result per cycle from the back-end sequencer while its output is free or
// being popped; a byte gives 4 pulse results, or 5 with the closing burst of a frame's last byte.
// Front queue holds two bytes; full depends only on that queue, not on pop.
// Reset (synchronous, active low) empties both queues and reloads the default
// timing registers.
module ppm_ir_symbol_encoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [ppmenc_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                              i_frame_end,
    output logic                              empty,
    input  logic                              pop,
    output logic [ppmenc_pkg::TICK_W-1:0]     o_burst_len,
    output logic [ppmenc_pkg::TICK_W-1:0]     o_gap_len,
    output logic [ppmenc_pkg::SYM_W-1:0]      o_symbol_value,
    output logic                              o_closing,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [ppmenc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppmenc_pkg::TICK_W-1:0]     i_cfg_wdata
);
    import ppmenc_pkg::*;

    t_cfg      w_cfg;
    t_cmd_chan w_chan;
    logic      w_cmd_pop;
    t_result   w_res;

    ppmenc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ppmenc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_chan      (w_chan),
        .i_cmd_pop   (w_cmd_pop)
    );

    ppmenc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_chan    (w_chan),
        .o_cmd_pop (w_cmd_pop),
        .i_cfg     (w_cfg),
        .empty     (empty),
        .pop       (pop),
        .o_res     (w_res)
    );

    assign o_burst_len    = w_res.burst_len;
    assign o_gap_len      = w_res.gap_len;
    assign o_symbol_value = w_res.symbol_value;
    assign o_closing      = w_res.closing;
    assign o_last         = w_res.last;

endmodule

// ===== rtl/ppmenc_cfg.sv =====
// Timing register file: burst length and the four symbol gap lengths.
// Depends on ppmenc_pkg.
module ppmenc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ppmenc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppmenc_pkg::TICK_W-1:0]     i_cfg_wdata,
    output ppmenc_pkg::t_cfg                  o_cfg
);
    import ppmenc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BURST: n_cfg.burst  = i_cfg_wdata;
                REG_GAP0:  n_cfg.gap[0] = i_cfg_wdata;
                REG_GAP1:  n_cfg.gap[1] = i_cfg_wdata;
                REG_GAP2:  n_cfg.gap[2] = i_cfg_wdata;
                REG_GAP3:  n_cfg.gap[3] = i_cfg_wdata;
                default:   n_cfg = r_cfg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burst  <= BURST_RST;
            r_cfg.gap[0] <= GAP0_RST;
            r_cfg.gap[1] <= GAP1_RST;
            r_cfg.gap[2] <= GAP2_RST;
            r_cfg.gap[3] <= GAP3_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/ppmenc_front.sv =====
// Front end: accepts frame bytes and holds them in a two-entry command queue.
// Depends on ppmenc_pkg.
module ppmenc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [ppmenc_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                           i_frame_end,
    output ppmenc_pkg::t_cmd_chan          o_chan,
    input  logic                           i_cmd_pop
);
    import ppmenc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;
    logic       w_push_ok;
    logic       w_pop_ok;

    assign full      = r_cnt[1];
    assign w_push_ok = push && !full;
    assign w_pop_ok  = i_cmd_pop && (r_cnt != 2'd0);

    always_comb begin
        n_wr  = r_wr ^ w_push_ok;
        n_rd  = r_rd ^ w_pop_ok;
        n_cnt = r_cnt;
        if (w_push_ok && !w_pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= '{data_byte: i_data_byte, frame_end: i_frame_end};
        end
    end

    assign o_chan.valid = (r_cnt != 2'd0);
    assign o_chan.cmd   = r_mem[r_rd];

endmodule

// ===== rtl/ppmenc_back.sv =====
// Back end: steps through the symbols of each queued byte, one pulse per
// cycle while the output slot is free or being popped, into an output register. Depends on ppmenc_pkg.
module ppmenc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ppmenc_pkg::t_cmd_chan             i_chan,
    output logic                              o_cmd_pop,
    input  ppmenc_pkg::t_cfg                  i_cfg,
    output logic                              empty,
    input  logic                              pop,
    output ppmenc_pkg::t_result               o_res
);
    import ppmenc_pkg::*;

    logic [SEQ_W-1:0] r_seq;
    logic [SEQ_W-1:0] n_seq;
    logic             r_out_vld;
    logic             n_out_vld;
    t_result          r_res;
    t_result          w_res;
    logic             w_adv;
    logic [SYM_W-1:0] w_sym;
    logic             w_done;

    // Output slot is free, or being drained this cycle
    assign w_adv = !r_out_vld || pop;

    always_comb begin
        case (r_seq[1:0])
            2'd0:    w_sym = i_chan.cmd.data_byte[1:0];
            2'd1:    w_sym = i_chan.cmd.data_byte[3:2];
            2'd2:    w_sym = i_chan.cmd.data_byte[5:4];
            default: w_sym = i_chan.cmd.data_byte[7:6];
        endcase

        w_res.burst_len = i_cfg.burst;
        if (r_seq == SEQ_CLOSE) begin
            w_res.gap_len      = '0;
            w_res.symbol_value = '0;
            w_res.closing      = 1'b1;
            w_res.last         = 1'b1;
            w_done             = 1'b1;
        end else begin
            w_res.gap_len      = i_cfg.gap[w_sym];
            w_res.symbol_value = w_sym;
            w_res.closing      = 1'b0;
            w_res.last         = (r_seq == SEQ_LAST_SYM) && !i_chan.cmd.frame_end;
            w_done             = w_res.last;
        end
    end

    always_comb begin
        n_seq     = r_seq;
        n_out_vld = r_out_vld && !pop;
        o_cmd_pop = 1'b0;
        if (w_adv && i_chan.valid) begin
            n_out_vld = 1'b1;
            if (w_done) begin
                n_seq     = '0;
                o_cmd_pop = 1'b1;
            end else begin
                n_seq = r_seq + SEQ_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_chan.valid) begin
            r_res <= w_res;
        end
    end

    assign empty = !r_out_vld;
    assign o_res = r_res;

endmodule

// ===== rtl/ppmenc_checker.sv =====
// Port-level checks for the PPM IR symbol encoder, bound to its top level.
// Depends on ppmenc_pkg and ppm_ir_symbol_encoder.
module ppmenc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              empty,
    input  logic                              full,
    input  logic                              pop,
    input  logic [ppmenc_pkg::TICK_W-1:0]     o_burst_len,
    input  logic [ppmenc_pkg::TICK_W-1:0]     o_gap_len,
    input  logic [ppmenc_pkg::SYM_W-1:0]      o_symbol_value,
    input  logic                              o_closing,
    input  logic                              o_last
);
    import ppmenc_pkg::*;

    // Reset leaves both sides drained
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // Closing burst carries fixed fields and ends its request
    a_closing_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_closing) |-> (o_last && o_gap_len == '0 && o_symbol_value == '0))
        else $error("malformed closing burst");

    // Within a request, pulses follow with no bubble
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |=> !empty)
        else $error("gap inside a request's pulse train");

    // A waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_burst_len) && $stable(o_gap_len)
                              && $stable(o_symbol_value) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind ppm_ir_symbol_encoder ppmenc_checker u_ppmenc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .full           (full),
    .pop            (pop),
    .o_burst_len    (o_burst_len),
    .o_gap_len      (o_gap_len),
    .o_symbol_value (o_symbol_value),
    .o_closing      (o_closing),
    .o_last         (o_last)
);

// ===== bench/tb_ppm_ir_symbol_encoder.sv =====
// Self-checking bench for ppm_ir_symbol_encoder: byte requests in, pulse results out.
// Depends on rtl/ppmenc_pkg.sv and rtl/ppm_ir_symbol_encoder.sv; nothing else is read.

module tb_ppm_ir_symbol_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmenc_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int IDLE_PERCENT    = 6;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_BYTES     = 50;
    localparam int MAX_FRAME_BYTES = 8;
    localparam logic [TICK_W-1:0] TICKS_MAX = {TICK_W{1'b1}};
    // first index past the timing registers; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(REG_GAP3) + 1'b1;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  push           = 1'b0;
    logic                  full;
    logic [BYTE_W-1:0]     i_data_byte    = '0;
    logic                  i_frame_end    = 1'b0;
    logic                  empty;
    logic                  pop            = 1'b0;
    logic [TICK_W-1:0]     o_burst_len;
    logic [TICK_W-1:0]     o_gap_len;
    logic [SYM_W-1:0]      o_symbol_value;
    logic                  o_closing;
    logic                  o_last;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [TICK_W-1:0]     i_cfg_wdata    = '0;

    // shadow timing registers and the pulses still owed by the block
    logic [TICK_W-1:0]     burst_set;
    logic [TICK_W-1:0]     gap_set [NUM_SYM];
    t_result               pulse_q [$];
    t_result               want;

    bit                    idle_en = 1'b1;
    int unsigned           errors  = 0;
    int unsigned           quiet_cycles = 0;

    ppm_ir_symbol_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_frame_end    (i_frame_end),
        .empty          (empty),
        .pop            (pop),
        .o_burst_len    (o_burst_len),
        .o_gap_len      (o_gap_len),
        .o_symbol_value (o_symbol_value),
        .o_closing      (o_closing),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // four symbol pulses, lowest pair first, plus a closing burst at frame end
    function automatic void expand_byte(input logic [BYTE_W-1:0] b, input logic fe);
        t_result p;
        for (int k = 0; k < NUM_SYM; k++) begin
            p.burst_len    = burst_set;
            p.symbol_value = b[SYM_W*k +: SYM_W];
            p.gap_len      = gap_set[p.symbol_value];
            p.closing      = 1'b0;
            p.last         = (k == NUM_SYM - 1) && !fe;
            pulse_q        = {pulse_q, p};
        end
        if (fe) begin
            p.burst_len    = burst_set;
            p.gap_len      = '0;
            p.symbol_value = '0;
            p.closing      = 1'b1;
            p.last         = 1'b1;
            pulse_q        = {pulse_q, p};
        end
    endfunction

    function automatic logic [TICK_W-1:0] pick_ticks();
        case ($urandom_range(4))
            0: return '0;
            1: return TICKS_MAX;
            default: return TICK_W'($urandom_range(TICKS_MAX));
        endcase
    endfunction

    // push stays high across back-to-back requests; only an idle cycle or wait_drained lowers it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fe);
        while (idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= fe;
        do @(posedge i_clk); while (full);
        expand_byte(b, fe);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        case (idx)
            REG_BURST: burst_set  = v;
            REG_GAP0:  gap_set[0] = v;
            REG_GAP1:  gap_set[1] = v;
            REG_GAP2:  gap_set[2] = v;
            REG_GAP3:  gap_set[3] = v;
            default: ;
        endcase
    endtask

    task automatic load_timing(input logic [TICK_W-1:0] b, g0, g1, g2, g3);
        write_reg(REG_BURST, b);
        write_reg(REG_GAP0, g0);
        write_reg(REG_GAP1, g1);
        write_reg(REG_GAP2, g2);
        write_reg(REG_GAP3, g3);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // every owed pulse out, then a spare drain wait so the sequencer is surely idle
    task automatic wait_drained();
        push <= 1'b0;
        while (pulse_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_default_timing();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE4, 1'b0);
        send_byte(8'h1B, 1'b1);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_timing_extremes();
        load_timing('0, '0, '0, '0, '0);
        send_byte(8'hE4, 1'b1);
        send_byte(8'hFF, 1'b0);
        wait_drained();
        load_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
        send_byte(8'hE4, 1'b1);
        send_byte(8'h00, 1'b0);
        wait_drained();
        // distinct values per register catch swapped gap selection
        load_timing(15'h2AAA, 15'h5555, 15'h0001, 15'h4000, 15'h3FFF);
        send_byte(8'hE4, 1'b0);
        send_byte(8'h1B, 1'b1);
        send_byte(8'h55, 1'b0);
        wait_drained();
    endtask

    task automatic test_unused_registers();
        for (int r = REG_UNUSED_LO; r < 2**CFG_IDX_W; r++) begin
            write_reg(CFG_IDX_W'(r), TICKS_MAX);
            write_reg(CFG_IDX_W'(r), '0);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_byte(8'hE4, 1'b1);
        send_byte(8'hAA, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int sent;
        int len;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
            // one phase runs flat out on both sides
            idle_en <= (ph != 2);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                len = $urandom_range(1, MAX_FRAME_BYTES);
                for (int j = 0; j < len; j++) begin
                    send_byte(BYTE_W'($urandom_range(255)), j == len - 1);
                    sent++;
                end
            end
            wait_drained();
        end
        idle_en <= 1'b1;
    endtask

    always @(posedge i_clk) begin
        pop <= !idle_en || ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic check_field(input string what, input logic [TICK_W-1:0] exp_v,
                               input logic [TICK_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pulse_q.size() == 0) begin
                $display("%0t: unexpected pulse, expected none, got burst %0d gap %0d sym %0d",
                         $time, o_burst_len, o_gap_len, o_symbol_value);
                errors++;
            end else begin
                want = pulse_q.pop_front();
                check_field("burst_len",    want.burst_len,    o_burst_len);
                check_field("gap_len",      want.gap_len,      o_gap_len);
                check_field("symbol_value", TICK_W'(want.symbol_value),
                            TICK_W'(o_symbol_value));
                check_field("closing",      TICK_W'(want.closing), TICK_W'(o_closing));
                check_field("last",         TICK_W'(want.last),    TICK_W'(o_last));
            end
        end
    end

    // counts cycles with neither a request nor a pulse accepted
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        burst_set  = BURST_RST;
        gap_set[0] = GAP0_RST;
        gap_set[1] = GAP1_RST;
        gap_set[2] = GAP2_RST;
        gap_set[3] = GAP3_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_timing();
        test_timing_extremes();
        test_unused_registers();
        test_random_frames();

        wait_drained();
        if (pulse_q.size() != 0) begin
            $display("%0t: %0d pulses never arrived", $time, pulse_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
